// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, cond, prop)

`define ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// ===== rtl/resamp_pkg.sv =====
// ---------------------------------------------------------------------------
// resamp_pkg
// Types and constants of the rectangle edge sampler.
// ---------------------------------------------------------------------------
package resamp_pkg;

    localparam int MAX_EDGE_POINTS = 16;

    localparam int COORD_W = 32;
    localparam int WIDTH_W = 31;
    localparam int MAG_W   = 32;
    localparam int PROD_W  = 2 * MAG_W;
    localparam int LEN_W   = 2 * MAG_W + 1;
    localparam int W2_W    = 2 * WIDTH_W;
    localparam int ACC_W   = W2_W + $clog2((MAX_EDGE_POINTS + 1) * (MAX_EDGE_POINTS + 1) + 1);
    localparam int CNT_W   = $clog2(MAX_EDGE_POINTS + 1);
    localparam int PART_W  = $clog2(MAX_EDGE_POINTS + 2);
    localparam int FR_W    = PART_W + 2;
    localparam int DIVC_W  = $clog2(MAG_W);

    localparam int          APB_DATA_W  = 32;
    localparam int          APB_ADDR_W  = 3;
    localparam logic        REG_SAMPLING_WIDTH = 1'b0;
    localparam logic [30:0] SAMPLING_WIDTH_RST = 31'd256;

    localparam logic [2:0] KIND_CORNER0 = 3'd0;
    localparam logic [2:0] KIND_CORNER1 = 3'd1;
    localparam logic [2:0] KIND_CORNER2 = 3'd2;
    localparam logic [2:0] KIND_CORNER3 = 3'd3;
    localparam logic [2:0] KIND_LEFT    = 3'd4;
    localparam logic [2:0] KIND_RIGHT   = 3'd5;

    typedef struct packed {
        logic signed [COORD_W-1:0] corner0_x;
        logic signed [COORD_W-1:0] corner0_y;
        logic signed [COORD_W-1:0] corner1_x;
        logic signed [COORD_W-1:0] corner1_y;
        logic signed [COORD_W-1:0] corner2_x;
        logic signed [COORD_W-1:0] corner2_y;
        logic signed [COORD_W-1:0] corner3_x;
        logic signed [COORD_W-1:0] corner3_y;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [2:0]                point_kind;
        logic                      last_point;
    } t_out_word;

endpackage

// ===== rtl/rectangle_edge_sampler_unit.sv =====
// The first word leaves through the output register after S_WSQ and S_CSTART once a rectangle is taken.
// Each edge passes S_CSTART, S_DIFF, S_ABS, S_SQX, S_SQY, S_LEN and the count loop, then, when
// it has n > 0 extra points (the count saturating at MAX_EDGE_POINTS), the divider and
// S_STEP/S_EMIT per point, and S_CEND. The steps are set by the shared squarer, the serial count loop, and the
// bit-serial divider (one quotient bit per cycle, x and y lanes together).
// Reset: synchronous, active low; sampling_width returns to 256, outputs idle.
// ---------------------------------------------------------------------------
// rectangle_edge_sampler_unit
// Emits the four corners of a rectangle and evenly spaced points along the
// left and right edges, using one shared squarer and a bit-serial divider.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rectangle_edge_sampler_unit
    import resamp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_WSQ     = 14'b00000000000010,
        S_CSTART  = 14'b00000000000100,
        S_DIFF    = 14'b00000000001000,
        S_ABS     = 14'b00000000010000,
        S_SQX     = 14'b00000000100000,
        S_SQY     = 14'b00000001000000,
        S_LEN     = 14'b00000010000000,
        S_COUNT   = 14'b00000100000000,
        S_DIVINIT = 14'b00001000000000,
        S_DIV     = 14'b00010000000000,
        S_STEP    = 14'b00100000000000,
        S_EMIT    = 14'b01000000000000,
        S_CEND    = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_side;
    logic   r_out_valid;
    logic [WIDTH_W-1:0] r_width;

    t_in_word  r_in;
    t_out_word r_out;
    logic [W2_W-1:0]   r_w2;
    logic [MAG_W:0]    r_dx, r_dy;
    logic              r_negx, r_negy;
    logic [MAG_W-1:0]  r_magx, r_magy;
    logic [LEN_W-1:0]  r_len;
    logic [PROD_W-1:0] r_ysq;
    logic [ACC_W-1:0]  r_sq, r_t;
    logic [CNT_W-1:0]  r_k, r_n, r_i;
    logic [PART_W-1:0] r_p;
    logic [PART_W-1:0] r_remx, r_remy;
    logic [MAG_W-1:0]  r_quox, r_quoy;
    logic [DIVC_W-1:0] r_divcnt;
    logic [FR_W-1:0]   r_frx, r_fry;
    logic [MAG_W-1:0]  r_accx, r_accy;

    logic [COORD_W-1:0] sx, sy, ex, ey;
    logic [MAG_W-1:0]   mul_a;
    logic [PROD_W-1:0]  mul_p;
    logic               out_free;
    logic               emit;
    t_out_word          emit_data;
    logic [PART_W:0]    shx, shy;
    logic               qbx, qby;
    logic [FR_W-1:0]    two_p, sumx, sumy;
    logic               cyx, cyy;
    logic [MAG_W:0]     ptx, pty;
    logic               cfg_we;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_SAMPLING_WIDTH);
    assign prdata = (paddr[2] == REG_SAMPLING_WIDTH) ? {1'b0, r_width} : '0;

    // edge endpoints
    assign sx = r_side ? r_in.corner2_x : r_in.corner0_x;
    assign sy = r_side ? r_in.corner2_y : r_in.corner0_y;
    assign ex = r_side ? r_in.corner3_x : r_in.corner1_x;
    assign ey = r_side ? r_in.corner3_y : r_in.corner1_y;

    // shared squarer
    always_comb begin
        case (r_state)
            S_WSQ:   mul_a = {1'b0, r_width};
            S_SQX:   mul_a = r_magx;
            S_SQY:   mul_a = r_magy;
            default: mul_a = r_magx;
        endcase
    end
    assign mul_p = mul_a * mul_a;

    // divider step, both lanes
    assign shx = {r_remx, r_quox[MAG_W-1]};
    assign shy = {r_remy, r_quoy[MAG_W-1]};
    assign qbx = shx >= {1'b0, r_p};
    assign qby = shy >= {1'b0, r_p};

    // rounding accumulator step
    assign two_p = {1'b0, r_p, 1'b0};
    assign sumx  = r_frx + {1'b0, r_remx, 1'b0};
    assign sumy  = r_fry + {1'b0, r_remy, 1'b0};
    assign cyx   = sumx >= two_p;
    assign cyy   = sumy >= two_p;

    // interpolated point
    assign ptx = r_negx ? ({sx[COORD_W-1], sx} - {1'b0, r_accx})
                        : ({sx[COORD_W-1], sx} + {1'b0, r_accx});
    assign pty = r_negy ? ({sy[COORD_W-1], sy} - {1'b0, r_accy})
                        : ({sy[COORD_W-1], sy} + {1'b0, r_accy});

    assign out_free = !r_out_valid || !i_out_stall;
    assign emit = out_free && ((r_state == S_CSTART) || (r_state == S_EMIT) ||
                               (r_state == S_CEND));

    always_comb begin
        emit_data = '0;
        case (r_state)
            S_CSTART: begin
                emit_data.point_x    = sx;
                emit_data.point_y    = sy;
                emit_data.point_kind = r_side ? KIND_CORNER2 : KIND_CORNER0;
            end
            S_EMIT: begin
                emit_data.point_x    = ptx[COORD_W-1:0];
                emit_data.point_y    = pty[COORD_W-1:0];
                emit_data.point_kind = r_side ? KIND_RIGHT : KIND_LEFT;
            end
            S_CEND: begin
                emit_data.point_x    = ex;
                emit_data.point_y    = ey;
                emit_data.point_kind = r_side ? KIND_CORNER3 : KIND_CORNER1;
                emit_data.last_point = r_side;
            end
            default: emit_data = '0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_in_valid) n_state = S_WSQ;
            S_WSQ:     n_state = S_CSTART;
            S_CSTART:  if (out_free) n_state = S_DIFF;
            S_DIFF:    n_state = S_ABS;
            S_ABS:     n_state = S_SQX;
            S_SQX:     n_state = S_SQY;
            S_SQY:     n_state = S_LEN;
            S_LEN:     n_state = S_COUNT;
            S_COUNT: begin
                if (({{(ACC_W-LEN_W){1'b0}}, r_len} <= r_sq) ||
                    (r_k == CNT_W'(MAX_EDGE_POINTS))) begin
                    n_state = S_DIVINIT;
                end
            end
            S_DIVINIT: n_state = (r_n == '0) ? S_CEND : S_DIV;
            S_DIV:     if (r_divcnt == DIVC_W'(MAG_W - 1)) n_state = S_STEP;
            S_STEP:    n_state = S_EMIT;
            S_EMIT:    if (out_free) n_state = (r_i == r_n) ? S_CEND : S_STEP;
            S_CEND:    if (out_free) n_state = r_side ? S_IDLE : S_CSTART;
            default:   n_state = S_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_side      <= 1'b0;
            r_out_valid <= 1'b0;
            r_width     <= SAMPLING_WIDTH_RST;
        end else begin
            r_state <= n_state;
            if (cfg_we) r_width <= pwdata[WIDTH_W-1:0];
            if (r_state == S_IDLE) r_side <= 1'b0;
            else if ((r_state == S_CEND) && out_free) r_side <= 1'b1;
            if (emit) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) r_out <= emit_data;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) r_in <= i_in_data;
            end
            S_WSQ: begin
                r_w2 <= mul_p[W2_W-1:0];
            end
            S_DIFF: begin
                r_dx <= {ex[COORD_W-1], ex} - {sx[COORD_W-1], sx};
                r_dy <= {ey[COORD_W-1], ey} - {sy[COORD_W-1], sy};
            end
            S_ABS: begin
                r_negx <= r_dx[MAG_W];
                r_negy <= r_dy[MAG_W];
                r_magx <= r_dx[MAG_W] ? MAG_W'(-r_dx) : r_dx[MAG_W-1:0];
                r_magy <= r_dy[MAG_W] ? MAG_W'(-r_dy) : r_dy[MAG_W-1:0];
            end
            S_SQX: begin
                r_len <= {1'b0, mul_p};
            end
            S_SQY: begin
                r_ysq <= mul_p;
            end
            S_LEN: begin
                r_len <= r_len + {1'b0, r_ysq};
                r_sq  <= ACC_W'(r_w2);
                r_t   <= ACC_W'(r_w2) + (ACC_W'(r_w2) << 1);
                r_k   <= CNT_W'(1);
                r_n   <= '0;
            end
            S_COUNT: begin
                if ({{(ACC_W-LEN_W){1'b0}}, r_len} > r_sq) begin
                    r_n  <= r_k;
                    r_k  <= r_k + CNT_W'(1);
                    r_sq <= r_sq + r_t;
                    r_t  <= r_t + (ACC_W'(r_w2) << 1);
                end
            end
            S_DIVINIT: begin
                r_p      <= PART_W'(r_n) + PART_W'(1);
                r_remx   <= '0;
                r_remy   <= '0;
                r_quox   <= r_magx;
                r_quoy   <= r_magy;
                r_divcnt <= '0;
                r_frx    <= FR_W'(r_n) + FR_W'(1);
                r_fry    <= FR_W'(r_n) + FR_W'(1);
                r_accx   <= '0;
                r_accy   <= '0;
                r_i      <= CNT_W'(1);
            end
            S_DIV: begin
                r_remx   <= qbx ? PART_W'(shx - {1'b0, r_p}) : shx[PART_W-1:0];
                r_remy   <= qby ? PART_W'(shy - {1'b0, r_p}) : shy[PART_W-1:0];
                r_quox   <= {r_quox[MAG_W-2:0], qbx};
                r_quoy   <= {r_quoy[MAG_W-2:0], qby};
                r_divcnt <= r_divcnt + DIVC_W'(1);
            end
            S_STEP: begin
                r_frx  <= cyx ? sumx - two_p : sumx;
                r_fry  <= cyy ? sumy - two_p : sumy;
                r_accx <= r_accx + r_quox + MAG_W'(cyx);
                r_accy <= r_accy + r_quoy + MAG_W'(cyy);
            end
            S_EMIT: begin
                if (out_free) r_i <= r_i + CNT_W'(1);
            end
            default: begin
                r_divcnt <= r_divcnt;
            end
        endcase
    end

    `ASSERT_IMPLY(a_count_max, i_clk, i_rst_n, r_state == S_DIVINIT, r_n <= CNT_W'(MAX_EDGE_POINTS))
    `ASSERT_IMPLY(a_emit_index, i_clk, i_rst_n, r_state == S_EMIT, (r_i != '0) && (r_i <= r_n))
    `ASSERT_IMPLY(a_frac_range, i_clk, i_rst_n, r_state == S_STEP, (r_frx < two_p) && (r_fry < two_p))
    `ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, emit && emit_data.last_point, r_state == S_IDLE)

endmodule
